// ===== rtl/jpeg_frame_size_scanner_assert.svh =====
// Assertion macros for the JPEG frame size scanner checker.
// No dependencies; included by the checker file.
`ifndef JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH
`define JPEG_FRAME_SIZE_SCANNER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define JFSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define JFSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/jfss_pkg.sv =====
// Shared types and constants for the JPEG frame size scanner.
// No dependencies; used by every other file of the block except the assertion macro header.
package jfss_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned OFS_W  = 3;

  localparam logic [BYTE_W-1:0] MK_PREFIX  = 8'hff;
  localparam logic [BYTE_W-1:0] MK_SOI     = 8'hd8;
  localparam logic [BYTE_W-1:0] MK_RST_LO  = 8'hd0;
  localparam logic [BYTE_W-1:0] MK_EOI     = 8'hd9;
  localparam logic [BYTE_W-1:0] MK_SOF_LO  = 8'hc0;
  localparam logic [BYTE_W-1:0] MK_SOF_HI  = 8'hcf;
  localparam logic [BYTE_W-1:0] MK_DHT     = 8'hc4;
  localparam logic [BYTE_W-1:0] MK_JPG     = 8'hc8;
  localparam logic [BYTE_W-1:0] MK_DAC     = 8'hcc;

  // Frame header positions after the length field
  localparam logic [OFS_W-1:0] OFS_HEIGHT_HI = 3'd1;
  localparam logic [OFS_W-1:0] OFS_HEIGHT_LO = 3'd2;
  localparam logic [OFS_W-1:0] OFS_WIDTH_HI  = 3'd3;
  localparam logic [OFS_W-1:0] OFS_WIDTH_LO  = 3'd4;
  localparam logic [OFS_W-1:0] OFS_END       = 3'd5;

  localparam logic [DIM_W-1:0] MIN_SEG_LEN = 16'd2;

  typedef enum logic [3:0] {
    PH_SOI0  = 4'd0,
    PH_SOI1  = 4'd1,
    PH_SCAN  = 4'd2,
    PH_MARK  = 4'd3,
    PH_LENHI = 4'd4,
    PH_LENLO = 4'd5,
    PH_SKIP  = 4'd6,
    PH_FRAME = 4'd7,
    PH_DONE  = 4'd8,
    PH_FAIL  = 4'd9
  } phase_t;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } jfss_res_t;

  function automatic logic is_sof(input logic [BYTE_W-1:0] m);
    return (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
           (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

  function automatic logic is_bare_marker(input logic [BYTE_W-1:0] m);
    return (m == MK_PREFIX) || ((m >= MK_RST_LO) && (m <= MK_EOI));
  endfunction

endpackage

// ===== rtl/jfss_if.sv =====
// Valid/ready channel interfaces for the JPEG frame size scanner.
// Depends on jfss_pkg for field widths.
interface jfss_in_if;
  logic                         valid;
  logic                         ready;
  logic [jfss_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jfss_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [jfss_pkg::DIM_W-1:0]   width;
  logic [jfss_pkg::DIM_W-1:0]   height;

  modport source (output valid, output found, output width, output height, input ready);
  modport sink   (input valid, input found, input width, input height, output ready);
endinterface

// ===== rtl/jfss_parser.sv =====
// Marker walker: consumes one byte per accepted transaction and emits the
// result on the last byte of a file. Depends on jfss_pkg.
module jfss_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [jfss_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  output logic                        res_valid,
  output jfss_pkg::jfss_res_t         res
);

  jfss_pkg::phase_t              phase_r, phase_nxt;
  logic [jfss_pkg::DIM_W-1:0]    skip_r, skip_nxt;
  logic [jfss_pkg::OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [jfss_pkg::BYTE_W-1:0]   len_hi_r, len_hi_nxt;
  logic [jfss_pkg::DIM_W-1:0]    height_r, height_nxt;
  logic [jfss_pkg::DIM_W-1:0]    width_r, width_nxt;
  logic                          sof_r, sof_nxt;
  logic [jfss_pkg::DIM_W-1:0]    seg_len;
  jfss_pkg::phase_t              phase_upd;

  assign seg_len = {len_hi_r, data_byte};

  always_comb begin
    phase_upd  = phase_r;
    skip_nxt   = skip_r;
    ofs_nxt    = ofs_r;
    len_hi_nxt = len_hi_r;
    height_nxt = height_r;
    width_nxt  = width_r;
    sof_nxt    = sof_r;
    unique case (phase_r)
      jfss_pkg::PH_SOI0: begin
        phase_upd = (data_byte == jfss_pkg::MK_PREFIX) ? jfss_pkg::PH_SOI1 : jfss_pkg::PH_FAIL;
      end
      jfss_pkg::PH_SOI1: begin
        phase_upd = (data_byte == jfss_pkg::MK_SOI) ? jfss_pkg::PH_SCAN : jfss_pkg::PH_FAIL;
      end
      jfss_pkg::PH_SCAN: begin
        if (data_byte == jfss_pkg::MK_PREFIX) begin
          phase_upd = jfss_pkg::PH_MARK;
        end
      end
      jfss_pkg::PH_MARK: begin
        if (jfss_pkg::is_bare_marker(data_byte)) begin
          phase_upd = jfss_pkg::PH_SCAN;
        end else begin
          sof_nxt   = jfss_pkg::is_sof(data_byte);
          phase_upd = jfss_pkg::PH_LENHI;
        end
      end
      jfss_pkg::PH_LENHI: begin
        len_hi_nxt = data_byte;
        phase_upd  = jfss_pkg::PH_LENLO;
      end
      jfss_pkg::PH_LENLO: begin
        skip_nxt = seg_len - jfss_pkg::MIN_SEG_LEN;
        if (seg_len < jfss_pkg::MIN_SEG_LEN) begin
          phase_upd = jfss_pkg::PH_FAIL;
        end else if (sof_r) begin
          ofs_nxt   = '0;
          phase_upd = jfss_pkg::PH_FRAME;
        end else if (seg_len == jfss_pkg::MIN_SEG_LEN) begin
          phase_upd = jfss_pkg::PH_SCAN;
        end else begin
          phase_upd = jfss_pkg::PH_SKIP;
        end
      end
      jfss_pkg::PH_SKIP: begin
        skip_nxt = skip_r - 1'b1;
        if (skip_r == {{(jfss_pkg::DIM_W-1){1'b0}}, 1'b1}) begin
          phase_upd = jfss_pkg::PH_SCAN;
        end
      end
      jfss_pkg::PH_FRAME: begin
        if (ofs_r == jfss_pkg::OFS_HEIGHT_HI) height_nxt = {data_byte, height_r[7:0]};
        if (ofs_r == jfss_pkg::OFS_HEIGHT_LO) height_nxt = {height_r[15:8], data_byte};
        if (ofs_r == jfss_pkg::OFS_WIDTH_HI)  width_nxt  = {data_byte, width_r[7:0]};
        if (ofs_r == jfss_pkg::OFS_WIDTH_LO)  width_nxt  = {width_r[15:8], data_byte};
        if (ofs_r >= jfss_pkg::OFS_END) begin
          phase_upd = jfss_pkg::PH_DONE;
        end else begin
          ofs_nxt = ofs_r + 1'b1;
        end
      end
      jfss_pkg::PH_DONE: begin
        phase_upd = jfss_pkg::PH_DONE;
      end
      default: begin
        phase_upd = jfss_pkg::PH_FAIL;
      end
    endcase

    // The last byte closes the file; the next transaction starts a new one
    phase_nxt = last_byte ? jfss_pkg::PH_SOI0 : phase_upd;
  end

  assign res_valid  = take && last_byte;
  assign res.found  = (phase_upd == jfss_pkg::PH_DONE);
  assign res.width  = res.found ? width_nxt  : '0;
  assign res.height = res.found ? height_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jfss_pkg::PH_SOI0;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  // Payload state is always written before it is read within a file
  always_ff @(posedge clk) begin
    if (take) begin
      skip_r   <= skip_nxt;
      ofs_r    <= ofs_nxt;
      len_hi_r <= len_hi_nxt;
      height_r <= height_nxt;
      width_r  <= width_nxt;
      sof_r    <= sof_nxt;
    end
  end

endmodule

// ===== rtl/jfss_out_buf.sv =====
// Two-entry result buffer between the parser and the result channel.
// Depends on jfss_pkg.
module jfss_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jfss_pkg::jfss_res_t push_res,
  output logic                has_room,
  output logic                head_valid,
  output jfss_pkg::jfss_res_t head,
  input  logic                pop_ready
);

  jfss_pkg::jfss_res_t head_r, head_nxt;
  jfss_pkg::jfss_res_t tail_r, tail_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pop;

  assign head_valid = (cnt_r != 2'd0);
  assign has_room   = (cnt_r != 2'd2);
  assign head       = head_r;
  assign pop        = head_valid && pop_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) head_nxt = push_res;
        else               tail_nxt = push_res;
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        head_nxt = tail_r;
        cnt_nxt  = cnt_r - 2'd1;
      end
      2'b11: begin
        // only reachable with one entry held
        head_nxt = push_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== rtl/jpeg_frame_size_scanner.sv =====
// JPEG frame size scanner: walks the markers of a JPEG byte stream and
// reports the frame dimensions once per file.
// Usage:
//   in_ch  : one file byte per transaction (data_byte), last_byte marks the
//            final byte of a file. Ready is high whenever the result buffer
//            has a free entry, independent of the current byte.
//   out_ch : one transaction per file, issued for its last byte: found,
//            width and height (width and height are 0 when not found).
// Throughput: one byte per cycle while the result buffer has room; the marker
// walk is a single state update per byte in the parser.
// Output: each result is registered in the result buffer and offered from its head.
// Stall: a two-entry result buffer absorbs a stalled receiver; bytes keep
// flowing until two results are waiting, then in_ch.ready drops until one
// is taken. A stalled result holds its value.
// Reset: synchronous, active low; the parser returns to expecting the
// start-of-image pair and the result buffer empties. After each last byte
// the parser also returns to that state for the next file.
// Depends on jfss_pkg, jfss_if, jfss_parser and jfss_out_buf.
module jpeg_frame_size_scanner (
  input  logic        clk,
  input  logic        rst_n,
  jfss_in_if.sink     in_ch,
  jfss_out_if.source  out_ch
);

  logic                take;
  logic                has_room;
  logic                res_valid;
  jfss_pkg::jfss_res_t res;
  jfss_pkg::jfss_res_t head;

  assign in_ch.ready = has_room;
  assign take        = in_ch.valid && has_room;

  jfss_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  jfss_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .has_room   (has_room),
    .head_valid (out_ch.valid),
    .head       (head),
    .pop_ready  (out_ch.ready)
  );

  assign out_ch.found  = head.found;
  assign out_ch.width  = head.width;
  assign out_ch.height = head.height;

endmodule

// ===== rtl/jfss_checker.sv =====
// Port-level checks for the JPEG frame size scanner, bound to the top level.
// Depends on jpeg_frame_size_scanner_assert.svh and jfss_pkg.
`include "jpeg_frame_size_scanner_assert.svh"

module jfss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_found,
  input logic [jfss_pkg::DIM_W-1:0] out_width,
  input logic [jfss_pkg::DIM_W-1:0] out_height
);

  `JFSS_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "result after reset")

  `JFSS_ASSERT(a_result_from_last, clk, rst_n,
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last), "result without last byte")

  `JFSS_ASSERT(a_backpressure_cause, clk, rst_n, !in_ready |-> out_valid,
    "input stalled with no pending result")

  `JFSS_ASSERT(a_not_found_zero, clk, rst_n,
    (out_valid && !out_found) |-> (out_width == '0 && out_height == '0),
    "dimensions nonzero on a miss")

  `JFSS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=>
    (out_valid && $stable(out_found) && $stable(out_width) && $stable(out_height)),
    "stalled result changed")

endmodule

bind jpeg_frame_size_scanner jfss_checker u_jfss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_byte),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_found  (out_ch.found),
  .out_width  (out_ch.width),
  .out_height (out_ch.height)
);

// ===== verif/tb_jpeg_frame_size_scanner.sv =====
// Self-checking testbench for the JPEG frame size scanner: short byte streams,
// a built-in scanner predictor and a result scoreboard on the valid/ready channels.
// Depends on rtl/jfss_pkg.sv, rtl/jfss_if.sv and the scanner RTL.
`timescale 1ns / 100ps

module tb_jpeg_frame_size_scanner;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 450;
  localparam int HOLD_FILE    = 6;
  localparam int BURST_LO     = 200;
  localparam int BURST_HI     = 320;

  // Tracks the marker walk per byte and queues one expected size per file
  class frame_size_scoreboard;
    jfss_pkg::phase_t    phase;
    logic [15:0]         skip_left;
    logic [3:0]          hdr_pos;
    logic [7:0]          len_hi;
    logic [15:0]         height_q;
    logic [15:0]         width_q;
    logic                in_sof;
    jfss_pkg::jfss_res_t expected_q[$];
    int unsigned         errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase     = jfss_pkg::PH_SOI0;
      skip_left = '0;
      hdr_pos   = '0;
      len_hi    = '0;
      height_q  = '0;
      width_q   = '0;
      in_sof    = 1'b0;
    endfunction

    function logic sof_code(logic [7:0] m);
      if (m < jfss_pkg::MK_SOF_LO || m > jfss_pkg::MK_SOF_HI) return 1'b0;
      return (m != jfss_pkg::MK_DHT) && (m != jfss_pkg::MK_JPG) && (m != jfss_pkg::MK_DAC);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [15:0]         seg_len;
      jfss_pkg::jfss_res_t res;
      case (phase)
        jfss_pkg::PH_SOI0:
          phase = (b == jfss_pkg::MK_PREFIX) ? jfss_pkg::PH_SOI1 : jfss_pkg::PH_FAIL;
        jfss_pkg::PH_SOI1:
          phase = (b == jfss_pkg::MK_SOI) ? jfss_pkg::PH_SCAN : jfss_pkg::PH_FAIL;
        jfss_pkg::PH_SCAN: if (b == jfss_pkg::MK_PREFIX) phase = jfss_pkg::PH_MARK;
        jfss_pkg::PH_MARK: begin
          if (b == jfss_pkg::MK_PREFIX ||
              (b >= jfss_pkg::MK_RST_LO && b <= jfss_pkg::MK_EOI)) begin
            phase = jfss_pkg::PH_SCAN;
          end else begin
            in_sof = sof_code(b);
            phase  = jfss_pkg::PH_LENHI;
          end
        end
        jfss_pkg::PH_LENHI: begin
          len_hi = b;
          phase  = jfss_pkg::PH_LENLO;
        end
        jfss_pkg::PH_LENLO: begin
          seg_len = {len_hi, b};
          if (seg_len < jfss_pkg::MIN_SEG_LEN) begin
            phase = jfss_pkg::PH_FAIL;
          end else if (in_sof) begin
            hdr_pos = '0;
            phase   = jfss_pkg::PH_FRAME;
          end else begin
            skip_left = seg_len - jfss_pkg::MIN_SEG_LEN;
            phase     = (skip_left == 0) ? jfss_pkg::PH_SCAN : jfss_pkg::PH_SKIP;
          end
        end
        jfss_pkg::PH_SKIP: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = jfss_pkg::PH_SCAN;
        end
        jfss_pkg::PH_FRAME: begin
          case (hdr_pos)
            jfss_pkg::OFS_HEIGHT_HI: height_q[15:8] = b;
            jfss_pkg::OFS_HEIGHT_LO: height_q[7:0]  = b;
            jfss_pkg::OFS_WIDTH_HI:  width_q[15:8]  = b;
            jfss_pkg::OFS_WIDTH_LO:  width_q[7:0]   = b;
            default: ;
          endcase
          if (hdr_pos >= jfss_pkg::OFS_END) phase = jfss_pkg::PH_DONE;
          else hdr_pos = hdr_pos + 1'b1;
        end
        jfss_pkg::PH_DONE: ;
        default: phase = jfss_pkg::PH_FAIL;
      endcase
      if (last) begin
        res.found  = (phase == jfss_pkg::PH_DONE);
        res.width  = res.found ? width_q : '0;
        res.height = res.found ? height_q : '0;
        expected_q.push_back(res);
        restart();
      end
    endfunction

    function void check_result(logic f, logic [15:0] w, logic [15:0] h);
      jfss_pkg::jfss_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b width=%0d height=%0d", $time, f, w, h);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (f !== want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found, f);
        errors++;
      end
      if (w !== want.width) begin
        $display("%0t: width mismatch: expected %0d, actual %0d", $time, want.width, w);
        errors++;
      end
      if (h !== want.height) begin
        $display("%0t: height mismatch: expected %0d, actual %0d", $time, want.height, h);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_req = 1'b0;
  int   idle_pct = 16;
  int   rand_bytes;
  int   files_sent;
  int   idle_cycles = 0;
  logic [7:0] file_bytes[$];
  frame_size_scoreboard sb;

  jfss_in_if  in_ch();
  jfss_out_if out_ch();

  jpeg_frame_size_scanner DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, l);
    rand_bytes++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  // Mostly well-formed files with random segments; some noise, broken SOI,
  // bad lengths and truncated endings mixed in
  task automatic build_random_file();
    int          kind;
    int          pick;
    int          seg_len;
    int          cut;
    logic [7:0]  mk;
    logic [15:0] dim_h;
    logic [15:0] dim_w;
    file_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    file_bytes.push_back(jfss_pkg::MK_PREFIX);
    file_bytes.push_back(jfss_pkg::MK_SOI);
    if (kind < 14) file_bytes[$urandom_range(1)] = 8'($urandom_range(255));
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(254)));
      end else if (pick < 55) begin
        file_bytes.push_back(jfss_pkg::MK_PREFIX);
        if ($urandom_range(10) == 10) file_bytes.push_back(jfss_pkg::MK_PREFIX);
        else file_bytes.push_back(jfss_pkg::MK_RST_LO + 8'($urandom_range(9)));
      end else begin
        case ($urandom_range(5))
          0: mk = jfss_pkg::MK_DHT;
          1: mk = jfss_pkg::MK_JPG;
          2: mk = jfss_pkg::MK_DAC;
          default: begin
            do mk = 8'($urandom_range(255));
            while (sb.sof_code(mk) || mk == jfss_pkg::MK_PREFIX ||
                   (mk >= jfss_pkg::MK_RST_LO && mk <= jfss_pkg::MK_EOI));
          end
        endcase
        pick = $urandom_range(99);
        if (pick < 5) seg_len = $urandom_range(1);
        else if (pick < 10) seg_len = 2;
        else if (pick < 12) seg_len = $urandom_range(200, 300);
        else seg_len = $urandom_range(3, 12);
        file_bytes.push_back(jfss_pkg::MK_PREFIX);
        file_bytes.push_back(mk);
        file_bytes.push_back(8'(seg_len >> 8));
        file_bytes.push_back(8'(seg_len));
        repeat (seg_len - 2) file_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if (kind >= 22) begin
      do mk = jfss_pkg::MK_SOF_LO + 8'($urandom_range(15));
      while (!sb.sof_code(mk));
      pick = $urandom_range(99);
      if (pick < 5) seg_len = $urandom_range(1);
      else if (pick < 15) seg_len = $urandom_range(2, 7);
      else seg_len = 8 + 3 * $urandom_range(1, 3);
      dim_h = rand_dim();
      dim_w = rand_dim();
      file_bytes.push_back(jfss_pkg::MK_PREFIX);
      file_bytes.push_back(mk);
      file_bytes.push_back(8'(seg_len >> 8));
      file_bytes.push_back(8'(seg_len));
      file_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'd8);
      file_bytes.push_back(dim_h[15:8]);
      file_bytes.push_back(dim_h[7:0]);
      file_bytes.push_back(dim_w[15:8]);
      file_bytes.push_back(dim_w[7:0]);
      file_bytes.push_back(8'($urandom_range(1, 3)));
      if (seg_len > 8) repeat (seg_len - 8) file_bytes.push_back(8'($urandom_range(255)));
    end
    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(1)) begin
      file_bytes.push_back(jfss_pkg::MK_PREFIX);
      file_bytes.push_back(jfss_pkg::MK_EOI);
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // largest dimensions, found on the byte eight after the frame marker
    file_bytes = '{jfss_pkg::MK_PREFIX, jfss_pkg::MK_SOI, jfss_pkg::MK_PREFIX,
                   jfss_pkg::MK_SOF_LO, 8'h00, 8'h11, 8'h08,
                   8'hff, 8'hff, 8'hff, 8'hff, 8'h03};
    send_file();
    // single-byte file with a bad start of image
    file_bytes = '{8'h00};
    send_file();
    // bad second start-of-image byte
    file_bytes = '{jfss_pkg::MK_PREFIX, 8'h00};
    send_file();
    // restart marker, fill pair, empty table segment, then a length below two
    file_bytes = '{jfss_pkg::MK_PREFIX, jfss_pkg::MK_SOI, jfss_pkg::MK_PREFIX,
                   jfss_pkg::MK_RST_LO, jfss_pkg::MK_PREFIX, jfss_pkg::MK_PREFIX,
                   jfss_pkg::MK_PREFIX, jfss_pkg::MK_DHT, 8'h00, 8'h02,
                   jfss_pkg::MK_PREFIX, jfss_pkg::MK_DAC, 8'h00, 8'h01};
    send_file();

    rand_bytes = 0;
    files_sent = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      if (files_sent == HOLD_FILE) hold_req <= 1'b1;
      idle_pct = (rand_bytes >= BURST_LO && rand_bytes < BURST_HI) ? 0 : 16;
      build_random_file();
      send_file();
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.found, out_ch.width, out_ch.height);
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== jpeg_frame_size_scanner.f =====
+incdir+rtl
rtl/jfss_pkg.sv
rtl/jfss_if.sv
rtl/jfss_parser.sv
rtl/jfss_out_buf.sv
rtl/jpeg_frame_size_scanner.sv
rtl/jfss_checker.sv
verif/tb_jpeg_frame_size_scanner.sv
